FILE: src/qau_pkg.sv
// Package for the quaternion arithmetic unit: widths, action codes and item types.
package qau_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int FRACTION_BITS = 14;
  localparam int ACTION_WIDTH  = 3;
  localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
  // Four full-width products summed need two more bits.
  localparam int SUM_WIDTH     = PROD_WIDTH + 2;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_ADD      = 3'd0,
    ACT_SUB      = 3'd1,
    ACT_SCALE    = 3'd2,
    ACT_HAMILTON = 3'd3,
    ACT_CONJ     = 3'd4,
    ACT_DOT      = 3'd5
  } action_e;

  // Spare action codes: the result is all zero with no clip flag.
  localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic        [ACTION_WIDTH-1:0] action;
    logic signed [DATA_WIDTH-1:0]   first_w;
    logic signed [DATA_WIDTH-1:0]   first_x;
    logic signed [DATA_WIDTH-1:0]   first_y;
    logic signed [DATA_WIDTH-1:0]   first_z;
    logic signed [DATA_WIDTH-1:0]   second_w;
    logic signed [DATA_WIDTH-1:0]   second_x;
    logic signed [DATA_WIDTH-1:0]   second_y;
    logic signed [DATA_WIDTH-1:0]   second_z;
    logic signed [DATA_WIDTH-1:0]   scale_factor;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_w;
    logic signed [DATA_WIDTH-1:0] result_x;
    logic signed [DATA_WIDTH-1:0] result_y;
    logic signed [DATA_WIDTH-1:0] result_z;
    logic                         saturated;
  } result_t;

endpackage

FILE: src/qau_datapath.sv
// Combinational datapath: sixteen product lanes, row sums, floor shift and saturation.
module qau_datapath
  import qau_pkg::*;
(
  input  item_t   item_i,
  output result_t result_o
);

  // Term sign codes for the product lanes.
  typedef enum logic [1:0] {
    TERM_OFF = 2'd0,
    TERM_ADD = 2'd1,
    TERM_SUB = 2'd2
  } term_e;

  // Hamilton product: minus terms, bit row*4+term.
  localparam logic [15:0] HAM_NEG = 16'b0100_0010_1000_1110;

  localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
    {{(SUM_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO = ~SAT_HI;

  logic signed [DATA_WIDTH-1:0] q1 [4];
  logic signed [DATA_WIDTH-1:0] q2 [4];
  logic signed [DATA_WIDTH-1:0] lhs [4][4];
  logic signed [DATA_WIDTH-1:0] rhs [4][4];
  term_e                        term_sel [4][4];
  logic signed [PROD_WIDTH-1:0] prod [4][4];
  logic signed [SUM_WIDTH-1:0]  row_sum [4];
  logic signed [SUM_WIDTH-1:0]  direct [4];
  logic signed [SUM_WIDTH-1:0]  wide [4];
  logic signed [DATA_WIDTH-1:0] clipped [4];
  logic [3:0]                   clip_hit;
  logic                         use_prod;

  assign q1[0] = item_i.first_w;
  assign q1[1] = item_i.first_x;
  assign q1[2] = item_i.first_y;
  assign q1[3] = item_i.first_z;
  assign q2[0] = item_i.second_w;
  assign q2[1] = item_i.second_x;
  assign q2[2] = item_i.second_y;
  assign q2[3] = item_i.second_z;

  // Select lane operands and term signs per action.
  always_comb begin
    use_prod = 1'b0;
    for (int r = 0; r < 4; r++) begin
      direct[r] = '0;
      for (int t = 0; t < 4; t++) begin
        lhs[r][t]      = q1[t];
        rhs[r][t]      = q2[r ^ t];
        term_sel[r][t] = TERM_OFF;
      end
    end
    case (item_i.action)
      ACT_ADD: begin
        for (int r = 0; r < 4; r++) begin
          direct[r] = SUM_WIDTH'(q1[r]) + SUM_WIDTH'(q2[r]);
        end
      end
      ACT_SUB: begin
        for (int r = 0; r < 4; r++) begin
          direct[r] = SUM_WIDTH'(q1[r]) - SUM_WIDTH'(q2[r]);
        end
      end
      ACT_SCALE: begin
        use_prod = 1'b1;
        for (int r = 0; r < 4; r++) begin
          lhs[r][0]      = item_i.scale_factor;
          rhs[r][0]      = q1[r];
          term_sel[r][0] = TERM_ADD;
        end
      end
      ACT_HAMILTON: begin
        use_prod = 1'b1;
        for (int r = 0; r < 4; r++) begin
          for (int t = 0; t < 4; t++) begin
            term_sel[r][t] = HAM_NEG[r*4+t] ? TERM_SUB : TERM_ADD;
          end
        end
      end
      ACT_CONJ: begin
        direct[0] = SUM_WIDTH'(q1[0]);
        for (int r = 1; r < 4; r++) begin
          direct[r] = -SUM_WIDTH'(q1[r]);
        end
      end
      ACT_DOT: begin
        // Row zero of the lane grid pairs q1[t] with q2[t].
        use_prod = 1'b1;
        for (int t = 0; t < 4; t++) begin
          term_sel[0][t] = TERM_ADD;
        end
      end
      default: begin
        use_prod = 1'b0;
      end
    endcase
  end

  // Multiply each lane, sum each row, floor shift and clip.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_sum[r] = '0;
      for (int t = 0; t < 4; t++) begin
        prod[r][t] = lhs[r][t] * rhs[r][t];
        case (term_sel[r][t])
          TERM_ADD: row_sum[r] = row_sum[r] + SUM_WIDTH'(prod[r][t]);
          TERM_SUB: row_sum[r] = row_sum[r] - SUM_WIDTH'(prod[r][t]);
          default:  row_sum[r] = row_sum[r];
        endcase
      end
      wide[r] = use_prod ? (row_sum[r] >>> FRACTION_BITS) : direct[r];
      if (wide[r] > SAT_HI) begin
        clipped[r]  = DATA_WIDTH'(SAT_HI);
        clip_hit[r] = 1'b1;
      end else if (wide[r] < SAT_LO) begin
        clipped[r]  = DATA_WIDTH'(SAT_LO);
        clip_hit[r] = 1'b1;
      end else begin
        clipped[r]  = wide[r][DATA_WIDTH-1:0];
        clip_hit[r] = 1'b0;
      end
    end
  end

  assign result_o.result_w  = clipped[0];
  assign result_o.result_x  = clipped[1];
  assign result_o.result_y  = clipped[2];
  assign result_o.result_z  = clipped[3];
  assign result_o.saturated = |clip_hit;

endmodule

FILE: src/quaternion_arithmetic_unit_top.sv
// Top level of the quaternion arithmetic unit: input register, datapath, result register.
//
// Quaternion arithmetic on signed Q1.14 values: add, subtract, scale, Hamilton
// product, conjugate and dot product. An item is taken on any clock edge with
// start high; busy never rises, so one item can be issued every cycle. The
// result sits on result_o with done_o high for exactly one cycle, after the
// item passes through the input register, then a single pass through the
// multiply/sum/shift/saturate datapath into the result register. The
// receiver cannot stall the unit and must capture each result in its cycle.
module quaternion_arithmetic_unit_top
  import qau_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    done_o
);

  logic    in_valid_q;
  item_t   item_q;
  logic    done_q;
  result_t result_q;
  result_t result_d;
  logic    take;

  // The unit is fully pipelined and never pushes back.
  assign busy = 1'b0;
  assign take = start && !busy;

  // Hold the accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  qau_datapath u_datapath (
    .item_i   (item_q),
    .result_o (result_d)
  );

  // Advance the result into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

`ifndef SYNTHESIS
  // Every taken item yields a result.
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##2 done_o)
    else $error("accepted item produced no result");

  // No result without an item taken before it.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> ##2 !done_o)
    else $error("result strobe without an accepted item");

  // Dot product leaves the vector part at zero.
  a_dot_vector_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(item_q.action) == ACT_DOT |->
      result_o.result_x == '0 && result_o.result_y == '0 && result_o.result_z == '0)
    else $error("dot product result has a nonzero vector part");

  // Unused action codes give an all-zero, unclipped result.
  a_unused_action_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(item_q.action) == ACT_SPARE_LO ||
               $past(item_q.action) == ACT_SPARE_HI) |->
      result_o == '0)
    else $error("unused action code produced a nonzero result");
`endif

endmodule
